/* rtl/quicksort_explicit_stack_macros.svh */
// Assertion macros shared by the checker of the sorter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef QUICKSORT_EXPLICIT_STACK_MACROS_SVH
`define QUICKSORT_EXPLICIT_STACK_MACROS_SVH

// Same-cycle implication under reset.
`define QS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication under reset.
`define QS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

/* rtl/qsort_pkg.sv */
// Shared constants and types of the sorter.
// No dependencies.
`default_nettype none

package qsort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef struct packed {
        logic   load;
        logic   pop;
        value_t value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/qsort_in_if.sv */
// Input channel of the sorter: one element per item.
// Depends on qsort_pkg.
`default_nettype none

interface qsort_in_if;
    import qsort_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* rtl/qsort_out_if.sv */
// Output channel of the sorter: one sorted element per item.
// Depends on qsort_pkg.
`default_nettype none

interface qsort_out_if;
    import qsort_pkg::*;

    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   last_out;
    logic   overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

/* rtl/quicksort_explicit_stack.sv */
// Top level of the sorter: sequencer plus a row of MAX_ITEMS sorting cells.
// Depends on qsort_pkg, qsort_in_if, qsort_out_if, qsort_cell, qsort_ctrl.
//
// Elements arrive one item per cycle while the sequencer is loading and are
// inserted in ascending order into a row of 64 cells as they come in, each
// cell comparing the new element with its own in the same cycle, so no extra
// sort time follows loading. From the cycle after the item marked last (or the
// 64th item), the row shifts toward cell 0 and one sorted item leaves per cycle
// while the output is ready; the input stays stalled until the final sorted
// item, marked last_out, is taken. A set cut at 64 elements carries overflow
// on all its results. No clearing pass after reset.
`default_nettype none

module quicksort_explicit_stack (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qsort_in_if.sink    elem,
    qsort_out_if.source result
);
    import qsort_pkg::*;

    cell_cmd_t cmd;
    logic      take_w  [MAX_ITEMS];
    logic      valid_w [MAX_ITEMS];
    value_t    value_w [MAX_ITEMS];

    qsort_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (elem.valid),
        .in_last      (elem.last),
        .in_value     (elem.value),
        .in_ready     (elem.ready),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_last     (result.last_out),
        .out_overflow (result.overflow),
        .cmd          (cmd)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic   l_take;
        logic   l_valid;
        value_t l_value;
        logic   r_valid;
        value_t r_value;

        if (i == 0)
        begin : g_head
            assign l_take  = 1'b0;
            assign l_valid = 1'b0;
            assign l_value = '0;
        end
        else
        begin : g_body
            assign l_take  = take_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_value = value_w[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
        end
        else
        begin : g_next
            assign r_valid = valid_w[i+1];
            assign r_value = value_w[i+1];
        end

        qsort_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_take   (l_take),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .right_valid (r_valid),
            .right_value (r_value),
            .take        (take_w[i]),
            .valid       (valid_w[i]),
            .value       (value_w[i])
        );
    end

    assign result.sorted_value = value_w[0];

endmodule

`default_nettype wire

/* rtl/qsort_cell.sv */
// One cell of the sorting row: holds one element, kept ascending along the row.
// Depends on qsort_pkg.
`default_nettype none

module qsort_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qsort_pkg::cell_cmd_t cmd,
    input  wire logic                 left_take,
    input  wire logic                 left_valid,
    input  wire qsort_pkg::value_t    left_value,
    input  wire logic                 right_valid,
    input  wire qsort_pkg::value_t    right_value,
    output logic                      take,
    output logic                      valid,
    output qsort_pkg::value_t         value
);
    import qsort_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;

    assign take  = !valid_reg || (cmd.value < value_reg);
    assign valid = valid_reg;
    assign value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.pop)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
        else if (cmd.load && take)
        begin
            if (left_take)
            begin
                valid_next = left_valid;
                value_next = left_value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = cmd.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

/* rtl/qsort_ctrl.sv */
// Load/emit sequencer of the sorter: element count, overflow flag, commands to the row.
// Depends on qsort_pkg.
`default_nettype none

module qsort_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    input  wire qsort_pkg::value_t  in_value,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_last,
    output logic                    out_overflow,
    output qsort_pkg::cell_cmd_t    cmd
);
    import qsort_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    logic   mode_reg;
    logic   mode_next;
    count_t count_reg;
    count_t count_next;
    logic   ovf_reg;
    logic   ovf_next;
    logic   in_acc;
    logic   out_acc;
    logic   full;

    assign in_ready     = (mode_reg == MODE_LOAD);
    assign out_valid    = (mode_reg == MODE_EMIT);
    assign out_last     = (count_reg == count_t'(1));
    assign out_overflow = ovf_reg;
    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign full         = ((count_reg + count_t'(1)) == count_t'(MAX_ITEMS));

    assign cmd.load  = in_acc;
    assign cmd.pop   = out_acc;
    assign cmd.value = in_value;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (mode_reg)
            MODE_LOAD:
            begin
                if (in_acc)
                begin
                    count_next = count_reg + count_t'(1);
                    if (in_last || full)
                    begin
                        mode_next = MODE_EMIT;
                        ovf_next  = !in_last;
                    end
                end
            end
            MODE_EMIT:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - count_t'(1);
                    if (out_last)
                    begin
                        mode_next = MODE_LOAD;
                        ovf_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/qsort_checker.sv */
// Port-level checks of the sorter, bound to the top level.
// Depends on quicksort_explicit_stack_macros.svh and quicksort_explicit_stack.
`default_nettype none

`include "quicksort_explicit_stack_macros.svh"

module qsort_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire logic in_last,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire logic out_last
);

    `QS_ASSERT_NOW(a_phase_excl, 1'b1, !(in_ready && out_valid))
    `QS_ASSERT_NEXT(a_emit_start, in_valid && in_ready && in_last, out_valid)
    `QS_ASSERT_NEXT(a_emit_cont, out_valid && out_ready && !out_last, out_valid)
    `QS_ASSERT_NEXT(a_emit_end, out_valid && out_ready && out_last, in_ready && !out_valid)

endmodule

bind quicksort_explicit_stack qsort_checker u_qsort_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (elem.valid),
    .in_ready  (elem.ready),
    .in_last   (elem.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_last  (result.last_out)
);

`default_nettype wire
